// File: design/cepb_pkg.sv
// ----------------------------------------------------------------------------
// cepb_pkg: shared types, cube geometry tables and helper functions
// Edge/face/corner tables of the unit cube and the face rule used when
// chaining crossed edges into polygons.
// ----------------------------------------------------------------------------
package cepb_pkg;

  localparam int EDGES   = 12;
  localparam int FACES   = 6;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef logic [7:0]  cube_t;
  typedef logic [3:0]  edge_t;
  typedef logic [11:0] emask_t;
  typedef logic [1:0]  coord_t;
  typedef logic [2:0]  corner_t;
  typedef logic [2:0]  face_t;

  // face layouts with set corners on a diagonal
  localparam logic [3:0] DIAG_A = 4'b0101;
  localparam logic [3:0] DIAG_B = 4'b1010;

  typedef struct packed {
    cube_t  cube;
    emask_t crossed;
  } cell_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_START,
    BK_SCAN
  } bk_state_t;

  // end corners of each edge
  localparam corner_t EDGE_CA [EDGES] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
                                          3'd6, 3'd7, 3'd0, 3'd1, 3'd2, 3'd3};
  localparam corner_t EDGE_CB [EDGES] = '{3'd1, 3'd2, 3'd3, 3'd0, 3'd5, 3'd6,
                                          3'd7, 3'd4, 3'd4, 3'd5, 3'd6, 3'd7};
  // faces bordering each edge
  localparam face_t EDGE_FA [EDGES] = '{3'd0, 3'd0, 3'd0, 3'd0, 3'd5, 3'd5,
                                        3'd5, 3'd5, 3'd4, 3'd1, 3'd2, 3'd3};
  localparam face_t EDGE_FB [EDGES] = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd1, 3'd2,
                                        3'd3, 3'd4, 3'd1, 3'd2, 3'd3, 3'd4};
  // corners of each face, in layout bit order
  localparam corner_t FACE_CORNER [FACES][4] = '{
    '{3'd0, 3'd1, 3'd2, 3'd3},
    '{3'd0, 3'd1, 3'd5, 3'd4},
    '{3'd1, 3'd2, 3'd6, 3'd5},
    '{3'd2, 3'd3, 3'd7, 3'd6},
    '{3'd3, 3'd0, 3'd4, 3'd7},
    '{3'd4, 3'd5, 3'd6, 3'd7}
  };
  // edge midpoints, half-cell units
  localparam coord_t EDGE_MX [EDGES] = '{2'd1, 2'd2, 2'd1, 2'd0, 2'd1, 2'd2,
                                         2'd1, 2'd0, 2'd0, 2'd2, 2'd2, 2'd0};
  localparam coord_t EDGE_MY [EDGES] = '{2'd0, 2'd0, 2'd0, 2'd0, 2'd2, 2'd2,
                                         2'd2, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1};
  localparam coord_t EDGE_MZ [EDGES] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd0, 2'd1,
                                         2'd2, 2'd1, 2'd0, 2'd0, 2'd2, 2'd2};

  // edges whose end corners differ
  function automatic emask_t crossed_edges(cube_t cube);
    emask_t m;
    for (int i = 0; i < EDGES; i++) begin
      m[i] = cube[EDGE_CA[i]] ^ cube[EDGE_CB[i]];
    end
    return m;
  endfunction

  // index of the lowest set bit (0 when none)
  function automatic edge_t lowest(emask_t m);
    edge_t idx;
    idx = '0;
    for (int i = EDGES - 1; i >= 0; i--) begin
      if (m[i]) idx = edge_t'(i);
    end
    return idx;
  endfunction

  // true when edge b may follow edge a: shared face exists and passes the rule
  function automatic logic face_ok(cube_t cube, edge_t a, edge_t b);
    face_t      f;
    logic       has_f;
    corner_t    v;
    logic       has_v;
    logic [3:0] lay;
    logic [2:0] cnt;
    logic       ok;
    has_f = 1'b1;
    if (EDGE_FA[a] == EDGE_FA[b])      f = EDGE_FA[a];
    else if (EDGE_FA[a] == EDGE_FB[b]) f = EDGE_FA[a];
    else if (EDGE_FB[a] == EDGE_FA[b]) f = EDGE_FB[a];
    else if (EDGE_FB[a] == EDGE_FB[b]) f = EDGE_FB[a];
    else begin
      f     = '0;
      has_f = 1'b0;
    end
    has_v = 1'b1;
    if (EDGE_CA[a] == EDGE_CA[b])      v = EDGE_CA[a];
    else if (EDGE_CA[a] == EDGE_CB[b]) v = EDGE_CA[a];
    else if (EDGE_CB[a] == EDGE_CA[b]) v = EDGE_CB[a];
    else if (EDGE_CB[a] == EDGE_CB[b]) v = EDGE_CB[a];
    else begin
      v     = '0;
      has_v = 1'b0;
    end
    for (int i = 0; i < 4; i++) begin
      lay[i] = cube[FACE_CORNER[f][i]];
    end
    cnt = 3'(lay[0]) + 3'(lay[1]) + 3'(lay[2]) + 3'(lay[3]);
    if (cnt == 3'd1 || cnt == 3'd3) ok = 1'b1;
    else if (cnt == 3'd2) begin
      if (has_v) ok = cube[v];
      else       ok = !(lay == DIAG_A || lay == DIAG_B);
    end else ok = 1'b0;
    return has_f && ok;
  endfunction

endpackage

// File: design/cepb_in_if.sv
// ----------------------------------------------------------------------------
// cepb_in_if: cell input channel
// valid/ready channel carrying the eight corner bits of one cell.
// ----------------------------------------------------------------------------
interface cepb_in_if;
  logic             valid;
  logic             ready;
  cepb_pkg::cube_t  cube_corners;

  modport source (output valid, output cube_corners, input ready);
  modport sink   (input valid, input cube_corners, output ready);
endinterface

// File: design/cepb_out_if.sv
// ----------------------------------------------------------------------------
// cepb_out_if: polygon point output channel
// valid/ready channel carrying one polygon point per word.
// ----------------------------------------------------------------------------
interface cepb_out_if;
  logic              valid;
  logic              ready;
  cepb_pkg::edge_t   edge_index;
  cepb_pkg::coord_t  point_x;
  cepb_pkg::coord_t  point_y;
  cepb_pkg::coord_t  point_z;
  logic              polygon_first;
  logic              cell_last;

  modport source (output valid, output edge_index, output point_x, output point_y,
                  output point_z, output polygon_first, output cell_last, input ready);
  modport sink   (input valid, input edge_index, input point_x, input point_y,
                  input point_z, input polygon_first, input cell_last, output ready);
endinterface

// File: design/cube_edge_polygon_builder.sv
// ----------------------------------------------------------------------------
// cube_edge_polygon_builder: marching-cubes cell polygon extraction
// Turns the eight corner bits of a cell into its surface polygons, sent
// as a stream of crossed-edge points.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake        | word
//  --------+-----+------------------+----------------------------------------
//  in_ch   | in  | valid/ready      | cube_corners
//  out_ch  | out | valid/ready      | edge_index, point_x/y/z, polygon_first,
//          |     |                  | cell_last
//
//  Walk: a load state, then one point per output word (3..12 points), a
//  rescan after each scan pass that appends before the cell is done, and
//  a restart per polygon close but the last. Empty/full cells: accept only.
//  Reset: synchronous, active low; clears queue pointers, walker state
//  and the output valid. No clearing pass.
//  Stalls: two-entry queue keeps in_ch accepting while out_ch is held, until it is full.
//
module cube_edge_polygon_builder (
  input  logic        clk,
  input  logic        rst_n,
  cepb_in_if.sink     in_ch,
  cepb_out_if.source  out_ch
);

  // front -> queue
  logic               push;
  cepb_pkg::cell_t    push_cell;
  // queue -> back
  logic               pop;
  cepb_pkg::cell_t    head;
  cepb_pkg::q_stat_t  q_stat;

  // classifier: crossed-edge mask, drops cells with no surface
  cepb_front u_front (
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_cell (push_cell)
  );

  cepb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cell (push_cell),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // walker: lowest free edge opens a polygon, ascending passes extend it
  cepb_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

  // queue never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!q_stat.full || pop))
    else $error("push into full queue");

  // walker never takes from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // only cells with a surface reach the walker
  a_push_crossed: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (push_cell.crossed != '0))
    else $error("cell without crossed edges queued");

endmodule

// File: design/cepb_front.sv
// ----------------------------------------------------------------------------
// cepb_front: cell classifier
// Finds the crossed edges of an incoming cell; empty and full cells are
// consumed without producing a queue entry.
// ----------------------------------------------------------------------------
module cepb_front (
  cepb_in_if.sink            in_ch,
  input  cepb_pkg::q_stat_t  q_stat,
  output logic               push,
  output cepb_pkg::cell_t    push_cell
);

  cepb_pkg::emask_t crossed;

  assign crossed         = cepb_pkg::crossed_edges(in_ch.cube_corners);
  assign in_ch.ready     = !q_stat.full;
  assign push            = in_ch.valid && !q_stat.full && (crossed != '0);
  assign push_cell.cube    = in_ch.cube_corners;
  assign push_cell.crossed = crossed;

endmodule

// File: design/cepb_queue.sv
// ----------------------------------------------------------------------------
// cepb_queue: front-to-back cell queue
// Small register FIFO decoupling the classifier from the polygon walker.
// ----------------------------------------------------------------------------
module cepb_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  cepb_pkg::cell_t    push_cell,
  input  logic               pop,
  output cepb_pkg::cell_t    head,
  output cepb_pkg::q_stat_t  q_stat
);

  cepb_pkg::cell_t                     mem_r [cepb_pkg::QDEPTH];
  logic [cepb_pkg::QPTR_W-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [cepb_pkg::QPTR_W-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [cepb_pkg::QCNT_W-1:0]         cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == cepb_pkg::QPTR_W'(cepb_pkg::QDEPTH - 1)) ? '0
                 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == cepb_pkg::QPTR_W'(cepb_pkg::QDEPTH - 1)) ? '0
                 : rd_ptr_r + 1'b1;
    end
    if (push && !pop)      cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cell;
  end

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == cepb_pkg::QCNT_W'(cepb_pkg::QDEPTH));
  assign q_stat.empty = (cnt_r == '0);

endmodule

// File: design/cepb_back.sv
// ----------------------------------------------------------------------------
// cepb_back: polygon walker
// Chains the crossed edges of one cell into polygons and emits one point
// per word through an output register.
// ----------------------------------------------------------------------------
module cepb_back (
  input  logic               clk,
  input  logic               rst_n,
  input  cepb_pkg::cell_t    head,
  input  cepb_pkg::q_stat_t  q_stat,
  output logic               pop,
  cepb_out_if.source         out_ch
);

  cepb_pkg::bk_state_t state_r, state_nxt;
  cepb_pkg::cube_t     cube_r, cube_nxt;
  cepb_pkg::emask_t    crossed_r, crossed_nxt;
  cepb_pkg::emask_t    used_r, used_nxt;
  cepb_pkg::edge_t     cur_r, cur_nxt;
  cepb_pkg::edge_t     pos_r, pos_nxt;
  logic                added_r, added_nxt;

  logic                ov_r, ov_nxt;
  cepb_pkg::edge_t     oedge_r, oedge_nxt;
  logic                ofirst_r, ofirst_nxt;
  logic                olast_r, olast_nxt;

  logic                can_emit;
  cepb_pkg::emask_t    free_m;
  cepb_pkg::emask_t    cand;
  cepb_pkg::edge_t     start_e;
  cepb_pkg::edge_t     scan_e;
  cepb_pkg::emask_t    start_used;
  cepb_pkg::emask_t    scan_used;

  always_comb begin
    can_emit = !ov_r || out_ch.ready;
    free_m   = crossed_r & ~used_r;
    for (int j = 0; j < cepb_pkg::EDGES; j++) begin
      cand[j] = free_m[j] && (cepb_pkg::edge_t'(j) >= pos_r)
             && cepb_pkg::face_ok(cube_r, cur_r, cepb_pkg::edge_t'(j));
    end
    start_e    = cepb_pkg::lowest(free_m);
    scan_e     = cepb_pkg::lowest(cand);
    start_used = used_r | (cepb_pkg::emask_t'(1) << start_e);
    scan_used  = used_r | (cepb_pkg::emask_t'(1) << scan_e);
  end

  always_comb begin
    state_nxt   = state_r;
    cube_nxt    = cube_r;
    crossed_nxt = crossed_r;
    used_nxt    = used_r;
    cur_nxt     = cur_r;
    pos_nxt     = pos_r;
    added_nxt   = added_r;
    pop         = 1'b0;
    ov_nxt      = ov_r && !out_ch.ready;
    oedge_nxt   = oedge_r;
    ofirst_nxt  = ofirst_r;
    olast_nxt   = olast_r;
    case (state_r)
      cepb_pkg::BK_IDLE: begin
        if (!q_stat.empty) begin
          pop         = 1'b1;
          cube_nxt    = head.cube;
          crossed_nxt = head.crossed;
          used_nxt    = '0;
          state_nxt   = cepb_pkg::BK_START;
        end
      end
      cepb_pkg::BK_START: begin
        if (can_emit) begin
          ov_nxt     = 1'b1;
          oedge_nxt  = start_e;
          ofirst_nxt = 1'b1;
          olast_nxt  = (start_used == crossed_r);
          used_nxt   = start_used;
          cur_nxt    = start_e;
          pos_nxt    = '0;
          added_nxt  = 1'b0;
          state_nxt  = (start_used == crossed_r) ? cepb_pkg::BK_IDLE : cepb_pkg::BK_SCAN;
        end
      end
      cepb_pkg::BK_SCAN: begin
        if (cand != '0) begin
          if (can_emit) begin
            ov_nxt     = 1'b1;
            oedge_nxt  = scan_e;
            ofirst_nxt = 1'b0;
            olast_nxt  = (scan_used == crossed_r);
            used_nxt   = scan_used;
            cur_nxt    = scan_e;
            pos_nxt    = scan_e + 1'b1;
            added_nxt  = 1'b1;
            if (scan_used == crossed_r) state_nxt = cepb_pkg::BK_IDLE;
          end
        end else if (added_r) begin
          // pass appended something: rescan from the bottom
          pos_nxt   = '0;
          added_nxt = 1'b0;
        end else begin
          state_nxt = cepb_pkg::BK_START;
        end
      end
      default: state_nxt = cepb_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cepb_pkg::BK_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cube_r    <= cube_nxt;
    crossed_r <= crossed_nxt;
    used_r    <= used_nxt;
    cur_r     <= cur_nxt;
    pos_r     <= pos_nxt;
    added_r   <= added_nxt;
    oedge_r   <= oedge_nxt;
    ofirst_r  <= ofirst_nxt;
    olast_r   <= olast_nxt;
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.edge_index    = oedge_r;
  assign out_ch.point_x       = cepb_pkg::EDGE_MX[oedge_r];
  assign out_ch.point_y       = cepb_pkg::EDGE_MY[oedge_r];
  assign out_ch.point_z       = cepb_pkg::EDGE_MZ[oedge_r];
  assign out_ch.polygon_first = ofirst_r;
  assign out_ch.cell_last     = olast_r;

endmodule

// File: sim/tb_polygon_pkg.sv
// ----------------------------------------------------------------------------
// tb_polygon_pkg: expected polygon points for the cell polygon builder
// Holds the point record, the cube geometry used for prediction, and a
// scoreboard that traces polygons per cell and checks each output word.
// ----------------------------------------------------------------------------
package tb_polygon_pkg;

  import cepb_pkg::cube_t;
  import cepb_pkg::edge_t;
  import cepb_pkg::coord_t;

  localparam int CUBE_EDGES   = 12;
  localparam int REPORT_LINES = 40;

  // face layouts whose two set corners sit on a diagonal
  localparam bit [3:0] DIAG_LO = 4'b0101;
  localparam bit [3:0] DIAG_HI = 4'b1010;

  // end corners of each edge
  localparam int TIP [CUBE_EDGES][2] = '{
    '{0, 1}, '{1, 2}, '{2, 3}, '{3, 0}, '{4, 5}, '{5, 6},
    '{6, 7}, '{7, 4}, '{0, 4}, '{1, 5}, '{2, 6}, '{3, 7}
  };
  // the two faces on either side of each edge
  localparam int SIDE [CUBE_EDGES][2] = '{
    '{0, 1}, '{0, 2}, '{0, 3}, '{0, 4}, '{5, 1}, '{5, 2},
    '{5, 3}, '{5, 4}, '{4, 1}, '{1, 2}, '{2, 3}, '{3, 4}
  };
  // corners of each face, bit order of the face layout
  localparam int FACE_CORNERS [6][4] = '{
    '{0, 1, 2, 3}, '{0, 1, 5, 4}, '{1, 2, 6, 5},
    '{2, 3, 7, 6}, '{3, 0, 4, 7}, '{4, 5, 6, 7}
  };
  // edge midpoints, half-cell units
  localparam int MID [CUBE_EDGES][3] = '{
    '{1, 0, 0}, '{2, 0, 1}, '{1, 0, 2}, '{0, 0, 1}, '{1, 2, 0}, '{2, 2, 1},
    '{1, 2, 2}, '{0, 2, 1}, '{0, 1, 0}, '{2, 1, 0}, '{2, 1, 2}, '{0, 1, 2}
  };

  typedef struct packed {
    edge_t  edge_index;
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
    logic   polygon_first;
    logic   cell_last;
  } poly_point_t;

  // may edge b follow edge a on their common face
  function automatic bit joins(cube_t c, int a, int b);
    int       f = -1;
    int       v = -1;
    bit [3:0] lay;
    int       ones;
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        if (f < 0 && SIDE[a][i] == SIDE[b][j]) f = SIDE[a][i];
        if (v < 0 && TIP[a][i] == TIP[b][j]) v = TIP[a][i];
      end
    end
    if (f < 0) return 1'b0;
    for (int k = 0; k < 4; k++) lay[k] = c[FACE_CORNERS[f][k]];
    ones = $countones(lay);
    if (ones == 1 || ones == 3) return 1'b1;
    if (ones != 2) return 1'b0;
    if (v < 0) return !(lay == DIAG_LO || lay == DIAG_HI);
    return c[v];
  endfunction

  function automatic poly_point_t make_point(int e, bit first);
    poly_point_t p;
    p.edge_index    = edge_t'(e);
    p.point_x       = coord_t'(MID[e][0]);
    p.point_y       = coord_t'(MID[e][1]);
    p.point_z       = coord_t'(MID[e][2]);
    p.polygon_first = first;
    p.cell_last     = 1'b0;
    return p;
  endfunction

  class polygon_checker;
    poly_point_t pending[$];
    int          mismatches;

    function new();
      mismatches = 0;
    endfunction

    function void report(string msg);
      if (mismatches < REPORT_LINES) $display("mismatch %0d: %s", mismatches, msg);
      mismatches++;
    endfunction

    // trace the polygons of one accepted cell and queue its points
    function void add_cell(cube_t c);
      int          hits[$];
      bit          taken[CUBE_EDGES] = '{default: 1'b0};
      poly_point_t pts[$];
      int          cur;
      int          left;
      int          added;
      cur = 0;
      for (int e = 0; e < CUBE_EDGES; e++) begin
        if (c[TIP[e][0]] != c[TIP[e][1]]) hits = {hits, e};
      end
      left = hits.size();
      while (left > 0) begin
        // new polygon at the lowest unused crossed edge
        for (int i = 0; i < hits.size(); i++) begin
          if (!taken[i]) begin
            cur      = i;
            taken[i] = 1'b1;
            left--;
            pts = {pts, make_point(hits[i], 1'b1)};
            break;
          end
        end
        // ascending passes; current edge moves as soon as one is appended
        added = 1;
        while (added != 0) begin
          added = 0;
          for (int i = 0; i < hits.size(); i++) begin
            if (!taken[i] && joins(c, hits[cur], hits[i])) begin
              pts = {pts, make_point(hits[i], 1'b0)};
              taken[i] = 1'b1;
              left--;
              added++;
              cur = i;
            end
          end
        end
      end
      if (pts.size() > 0) pts[pts.size() - 1].cell_last = 1'b1;
      pending = {pending, pts};
    endfunction

    function void compare(string name, int got, int want, int at);
      if (got != want)
        report($sformatf("%s got %0d want %0d (edge %0d)", name, got, want, at));
    endfunction

    function void check_point(poly_point_t got);
      poly_point_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected point, edge %0d", got.edge_index));
        return;
      end
      want = pending.pop_front();
      compare("edge_index", got.edge_index, want.edge_index, want.edge_index);
      compare("point_x", got.point_x, want.point_x, want.edge_index);
      compare("point_y", got.point_y, want.point_y, want.edge_index);
      compare("point_z", got.point_z, want.point_z, want.edge_index);
      compare("polygon_first", got.polygon_first, want.polygon_first, want.edge_index);
      compare("cell_last", got.cell_last, want.cell_last, want.edge_index);
    endfunction
  endclass

endpackage

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for cube_edge_polygon_builder
// Sends directed and random cells, traces the expected polygon points per
// cell and checks every output word in order, under varying back-pressure.
// ----------------------------------------------------------------------------
module tb_top;

  import cepb_pkg::cube_t;
  import tb_polygon_pkg::*;

  // idle cycles with no word moving on either side before giving up;
  // far above the worst cell cost plus a long sink stall
  localparam int WATCHDOG_LIMIT = 2000;
  // quiet cycles after the last point, covers one full cell walk
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_PER_PHASE = 129;

  logic clk = 1'b0;
  logic rst_n;

  cepb_in_if  in_ch ();
  cepb_out_if out_ch ();

  cube_edge_polygon_builder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  polygon_checker book;
  poly_point_t    seen;
  int             src_idle_pct;
  int             snk_idle_pct;
  int             quiet_cycles;

  // hand-picked cells: empty, full, every single corner, a few single holes,
  // diagonal and adjacent pairs on a face, and the classic ambiguous cases
  localparam cube_t DIRECTED [24] = '{
    8'h00, 8'hFF, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
    8'hFE, 8'h7F, 8'h05, 8'h0A, 8'h03, 8'h5A, 8'hA5, 8'h69, 8'h96, 8'h3C,
    8'hC3, 8'h0F, 8'h33, 8'h55
  };

  // Receive side: sample the word on the edge it moves, then pick next ready.
  // Watchdog shares the block since it needs the same edge view.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        seen.edge_index    = out_ch.edge_index;
        seen.point_x       = out_ch.point_x;
        seen.point_y       = out_ch.point_y;
        seen.point_z       = out_ch.point_z;
        seen.polygon_first = out_ch.polygon_first;
        seen.cell_last     = out_ch.cell_last;
        book.check_point(seen);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
          $display("tb_top: FAIL");
          $finish;
        end
      end
    end
    out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  // Offer one cell; valid stays up across back-to-back cells so it is never
  // dropped and raised in the same step.
  task automatic send_cell(input cube_t c);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.cube_corners <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    book.add_cell(c);
  endtask

  // Mostly uniform cells, some sparse ones (one or two set corners) and some
  // complemented cells so single-polygon and hole shapes show up often.
  function automatic cube_t pick_cube();
    cube_t c;
    c = cube_t'($urandom_range(0, 255));
    if ($urandom_range(0, 5) == 0)
      c = cube_t'(1 << $urandom_range(0, 7)) | cube_t'(1 << $urandom_range(0, 7));
    if ($urandom_range(0, 7) == 0) c = ~c;
    return c;
  endfunction

  task automatic wait_drained();
    while (book.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    book               = new();
    quiet_cycles       = 0;
    src_idle_pct       = 11;
    snk_idle_pct       = 69;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.cube_corners = '0;
    out_ch.ready       = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[k]) send_cell(DIRECTED[k]);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle_pct = 11;
          snk_idle_pct = 69;
        end
        1: begin
          src_idle_pct = 69;
          snk_idle_pct = 11;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      for (int k = 0; k < RANDOM_PER_PHASE; k++) send_cell(pick_cube());
      // hold the sender off once until every point in flight is out
      if (ph == 0) begin
        in_ch.valid <= 1'b0;
        wait_drained();
      end
    end

    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.pending.size() != 0)
      book.report($sformatf("%0d points never arrived", book.pending.size()));
    if (book.mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
design/cepb_pkg.sv
design/cepb_in_if.sv
design/cepb_out_if.sv
design/cepb_front.sv
design/cepb_queue.sv
design/cepb_back.sv
design/cube_edge_polygon_builder.sv
sim/tb_polygon_pkg.sv
sim/tb_top.sv
